// ===== design/i2c_master_register_access_defines.svh =====
// ----------------------------------------------------------------------------
// I2C register master - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define I2CMRA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("i2cmra: implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define I2CMRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("i2cmra: next-cycle check failed");

`endif

// ===== design/i2cmra_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C register master - package
// Codes, reset values and the word types shared by the design files.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

    localparam int WAIT_BITS_DEFAULT = 8;

    // Configuration reset values
    localparam logic [7:0] STRETCH_RESET  = 8'd80;
    localparam logic [7:0] ACK_WAIT_RESET = 8'd80;
    localparam logic [3:0] PULSES_RESET   = 4'd9;
    localparam logic [7:0] SETTLE_RESET   = 8'd10;

    // Configuration register indexes
    localparam logic [1:0] CFG_STRETCH = 2'd0;
    localparam logic [1:0] CFG_ACK_WAIT = 2'd1;
    localparam logic [1:0] CFG_PULSES = 2'd2;
    localparam logic [1:0] CFG_SETTLE = 2'd3;

    // Item modes
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_PROBE   = 3'd1;
    localparam logic [2:0] MODE_WRITE   = 3'd2;
    localparam logic [2:0] MODE_READ    = 3'd3;
    localparam logic [2:0] MODE_RECOVER = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NACK     = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;
    localparam logic [1:0] ST_ZERO_LEN = 2'd3;

    // Stream word widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_value;
        logic [7:0] read_count;
        logic       sda_level;
        logic       scl_level;
    } item_t;

    typedef struct packed {
        logic [7:0] clock_stretch_limit;
        logic [7:0] ack_wait_limit;
        logic [3:0] recovery_pulse_count;
        logic [7:0] recovery_settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic [7:0] received_byte;
        logic       byte_valid;
        logic       final_byte;
        logic       done_res;
        logic       busy_res;
        logic [1:0] status;
    } result_t;

endpackage

// ===== design/i2cmra_core.sv =====
// ----------------------------------------------------------------------------
// I2C register master - transaction core
// Holds the bus state and advances it by one step for every item.
// ----------------------------------------------------------------------------
module i2cmra_core #(
    parameter int WAIT_COUNTER_BITS = i2cmra_pkg::WAIT_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  i2cmra_pkg::item_t   item,
    input  i2cmra_pkg::cfg_t    cfg,
    output i2cmra_pkg::result_t res
);
    import i2cmra_pkg::*;

    localparam int WCB   = WAIT_COUNTER_BITS;
    localparam int CMP_W = (WCB > 8) ? WCB : 8;
    localparam logic [WCB-1:0] WAIT_MAX = '1;

    // Bus phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_START  = 4'd1;
    localparam logic [3:0] PH_TX     = 4'd2;
    localparam logic [3:0] PH_ACK    = 4'd3;
    localparam logic [3:0] PH_RX     = 4'd4;
    localparam logic [3:0] PH_MACK   = 4'd5;
    localparam logic [3:0] PH_STOP   = 4'd6;
    localparam logic [3:0] PH_SETTLE = 4'd7;
    localparam logic [3:0] PH_PULSE  = 4'd8;

    // Byte stage within a transaction
    localparam logic [1:0] STG_ADDR = 2'd0;
    localparam logic [1:0] STG_REG  = 2'd1;
    localparam logic [1:0] STG_DATA = 2'd2;

    typedef struct packed {
        logic [3:0] phase;
        logic [1:0] quarter;
        logic [2:0] operation;
        logic [3:0] bit_counter;
        logic [7:0] bytes_left;
        logic [7:0] shift_reg;
        logic [6:0] saved_address;
        logic [7:0] saved_register;
        logic [7:0] saved_value;
        logic [1:0] error_code;
        logic [1:0] stage;
        logic       scl_drive;
        logic       sda_drive;
    } state_t;

    state_t         st_reg, st_next;
    logic [WCB-1:0] wc_reg, wc_next;

    function automatic logic [WCB-1:0] wait_bump(input logic [WCB-1:0] wc);
        wait_bump = (wc != WAIT_MAX) ? wc + 1'b1 : wc;
    endfunction

    function automatic logic wait_over(input logic [WCB-1:0] wc, input logic [7:0] limit);
        logic [CMP_W-1:0] wc_x;
        logic [CMP_W-1:0] lim_x;
        wc_x = CMP_W'(wc);
        lim_x = CMP_W'(limit);
        wait_over = (wc_x >= lim_x) || (wc == WAIT_MAX);
    endfunction

    always_comb begin
        logic       ack_chk;
        logic [3:0] bc_inc;
        logic [7:0] rx_shift;
        logic       o_valid;
        logic       o_final;
        logic       o_done;
        logic [7:0] o_byte;

        st_next  = st_reg;
        wc_next  = wc_reg;
        ack_chk  = 1'b0;
        bc_inc   = st_reg.bit_counter + 4'd1;
        rx_shift = {st_reg.shift_reg[6:0], item.sda_level};
        o_valid  = 1'b0;
        o_final  = 1'b0;
        o_done   = 1'b0;
        o_byte   = '0;

        if (item.mode == MODE_TICK) begin
            if (st_reg.phase != PH_IDLE) begin
                case (st_reg.phase)
                    PH_START: begin
                        if (st_reg.quarter == 2'd0) begin
                            st_next.sda_drive = 1'b0;
                            st_next.scl_drive = 1'b0;
                            st_next.quarter = 2'd1;
                            wc_next = '0;
                        end else if (st_reg.quarter == 2'd1) begin
                            if (item.scl_level) begin
                                st_next.sda_drive = 1'b1;
                                st_next.quarter = 2'd2;
                                wc_next = '0;
                            end else begin
                                wc_next = wait_bump(wc_reg);
                                if (wait_over(wc_next, cfg.clock_stretch_limit)) begin
                                    st_next.error_code = ST_TIMEOUT;
                                    st_next.sda_drive = 1'b1;
                                    st_next.phase = PH_STOP;
                                    st_next.quarter = 2'd1;
                                    wc_next = '0;
                                end
                            end
                        end else begin
                            // Address byte; the read direction bit is set after the
                            // repeated start.
                            st_next.scl_drive = 1'b1;
                            st_next.shift_reg = {st_reg.saved_address,
                                                 st_reg.stage == STG_DATA};
                            st_next.bit_counter = '0;
                            st_next.phase = PH_TX;
                            st_next.quarter = 2'd0;
                            wc_next = '0;
                        end
                    end
                    PH_TX: begin
                        if (st_reg.quarter == 2'd0) begin
                            st_next.scl_drive = 1'b1;
                            st_next.sda_drive = ~st_reg.shift_reg[7];
                            st_next.quarter = 2'd1;
                            wc_next = '0;
                        end else if (st_reg.quarter == 2'd1) begin
                            st_next.scl_drive = 1'b0;
                            st_next.quarter = 2'd2;
                            wc_next = '0;
                        end else if (item.scl_level) begin
                            st_next.scl_drive = 1'b1;
                            st_next.shift_reg = {st_reg.shift_reg[6:0], 1'b0};
                            st_next.bit_counter = bc_inc;
                            st_next.phase = (bc_inc >= 4'd8) ? PH_ACK : PH_TX;
                            st_next.quarter = 2'd0;
                            wc_next = '0;
                        end else begin
                            wc_next = wait_bump(wc_reg);
                            if (wait_over(wc_next, cfg.clock_stretch_limit)) begin
                                st_next.error_code = ST_TIMEOUT;
                                st_next.sda_drive = 1'b1;
                                st_next.phase = PH_STOP;
                                st_next.quarter = 2'd1;
                                wc_next = '0;
                            end
                        end
                    end
                    PH_ACK: begin
                        if (st_reg.quarter == 2'd0) begin
                            st_next.sda_drive = 1'b0;
                            st_next.scl_drive = 1'b0;
                            st_next.quarter = 2'd1;
                            wc_next = '0;
                        end else if (st_reg.quarter == 2'd1) begin
                            if (item.scl_level) begin
                                wc_next = '0;
                                ack_chk = 1'b1;
                            end else begin
                                wc_next = wait_bump(wc_reg);
                                if (wait_over(wc_next, cfg.clock_stretch_limit)) begin
                                    st_next.error_code = ST_TIMEOUT;
                                    st_next.sda_drive = 1'b1;
                                    st_next.phase = PH_STOP;
                                    st_next.quarter = 2'd1;
                                    wc_next = '0;
                                end
                            end
                        end else begin
                            ack_chk = 1'b1;
                        end
                    end
                    PH_RX: begin
                        if (st_reg.quarter == 2'd0) begin
                            st_next.scl_drive = 1'b1;
                            st_next.quarter = 2'd1;
                            wc_next = '0;
                        end else if (st_reg.quarter == 2'd1) begin
                            st_next.scl_drive = 1'b0;
                            st_next.quarter = 2'd2;
                            wc_next = '0;
                        end else if (item.scl_level) begin
                            st_next.shift_reg = rx_shift;
                            st_next.scl_drive = 1'b1;
                            st_next.bit_counter = bc_inc;
                            st_next.quarter = 2'd0;
                            wc_next = '0;
                            if (bc_inc >= 4'd8) begin
                                o_valid = 1'b1;
                                o_byte = rx_shift;
                                o_final = (st_reg.bytes_left <= 8'd1);
                                st_next.phase = PH_MACK;
                            end else begin
                                st_next.phase = PH_RX;
                            end
                        end else begin
                            wc_next = wait_bump(wc_reg);
                            if (wait_over(wc_next, cfg.clock_stretch_limit)) begin
                                st_next.error_code = ST_TIMEOUT;
                                st_next.sda_drive = 1'b1;
                                st_next.phase = PH_STOP;
                                st_next.quarter = 2'd1;
                                wc_next = '0;
                            end
                        end
                    end
                    PH_MACK: begin
                        if (st_reg.quarter == 2'd0) begin
                            // The master acknowledges every byte but the last one.
                            st_next.scl_drive = 1'b1;
                            st_next.sda_drive = (st_reg.bytes_left > 8'd1);
                            st_next.quarter = 2'd1;
                            wc_next = '0;
                        end else if (st_reg.quarter == 2'd1) begin
                            st_next.scl_drive = 1'b0;
                            st_next.quarter = 2'd2;
                            wc_next = '0;
                        end else if (item.scl_level) begin
                            st_next.scl_drive = 1'b1;
                            st_next.sda_drive = 1'b0;
                            st_next.quarter = 2'd0;
                            wc_next = '0;
                            if (st_reg.bytes_left <= 8'd1) begin
                                st_next.bytes_left = '0;
                                st_next.phase = PH_STOP;
                            end else begin
                                st_next.bytes_left = st_reg.bytes_left - 8'd1;
                                st_next.bit_counter = '0;
                                st_next.shift_reg = '0;
                                st_next.phase = PH_RX;
                            end
                        end else begin
                            wc_next = wait_bump(wc_reg);
                            if (wait_over(wc_next, cfg.clock_stretch_limit)) begin
                                st_next.error_code = ST_TIMEOUT;
                                st_next.sda_drive = 1'b1;
                                st_next.phase = PH_STOP;
                                st_next.quarter = 2'd1;
                                wc_next = '0;
                            end
                        end
                    end
                    PH_STOP: begin
                        if (st_reg.quarter == 2'd0) begin
                            st_next.sda_drive = 1'b1;
                            st_next.quarter = 2'd1;
                            wc_next = '0;
                        end else if (st_reg.quarter == 2'd1) begin
                            st_next.scl_drive = 1'b0;
                            st_next.quarter = 2'd2;
                            wc_next = '0;
                        end else if (st_reg.quarter == 2'd2) begin
                            // A timeout here simply lets the stop go ahead.
                            if (item.scl_level) begin
                                st_next.quarter = 2'd3;
                                wc_next = '0;
                            end else begin
                                wc_next = wait_bump(wc_reg);
                                if (wait_over(wc_next, cfg.clock_stretch_limit)) begin
                                    st_next.quarter = 2'd3;
                                    wc_next = '0;
                                end
                            end
                        end else begin
                            st_next.sda_drive = 1'b0;
                            o_done = 1'b1;
                            st_next.phase = PH_IDLE;
                            st_next.quarter = 2'd0;
                            wc_next = '0;
                        end
                    end
                    PH_SETTLE: begin
                        wc_next = wait_bump(wc_reg);
                        if (wait_over(wc_next, cfg.recovery_settle_ticks)) begin
                            st_next.quarter = 2'd0;
                            wc_next = '0;
                            if (item.sda_level) begin
                                o_done = 1'b1;
                                st_next.phase = PH_IDLE;
                            end else begin
                                st_next.bit_counter = '0;
                                st_next.phase = PH_PULSE;
                            end
                        end
                    end
                    PH_PULSE: begin
                        if (st_reg.quarter == 2'd0) begin
                            st_next.scl_drive = 1'b1;
                            st_next.quarter = 2'd1;
                            wc_next = '0;
                        end else if (st_reg.quarter == 2'd1) begin
                            st_next.scl_drive = 1'b0;
                            st_next.quarter = 2'd2;
                            wc_next = '0;
                        end else begin
                            st_next.bit_counter = bc_inc;
                            wc_next = '0;
                            if (item.sda_level || (bc_inc >= cfg.recovery_pulse_count)) begin
                                st_next.error_code = ST_OK;
                                st_next.sda_drive = 1'b1;
                                st_next.phase = PH_STOP;
                                st_next.quarter = 2'd1;
                            end else begin
                                st_next.quarter = 2'd0;
                            end
                        end
                    end
                    default: begin
                        st_next.phase = PH_IDLE;
                        st_next.quarter = 2'd0;
                        wc_next = '0;
                    end
                endcase

                // Acknowledge sampling, shared by the clock-high and waiting steps.
                if (ack_chk) begin
                    if (!item.sda_level) begin
                        st_next.scl_drive = 1'b1;
                        wc_next = '0;
                        if ((st_reg.operation == MODE_PROBE) || (st_reg.stage >= STG_DATA)) begin
                            st_next.quarter = 2'd0;
                            if (st_reg.operation == MODE_READ) begin
                                st_next.bit_counter = '0;
                                st_next.shift_reg = '0;
                                st_next.sda_drive = 1'b0;
                                st_next.phase = PH_RX;
                            end else begin
                                st_next.phase = PH_STOP;
                            end
                        end else if (st_reg.stage == STG_ADDR) begin
                            st_next.stage = STG_REG;
                            st_next.shift_reg = st_reg.saved_register;
                            st_next.bit_counter = '0;
                            st_next.phase = PH_TX;
                            st_next.quarter = 2'd0;
                        end else begin
                            st_next.stage = STG_DATA;
                            st_next.quarter = 2'd0;
                            if (st_reg.operation == MODE_READ) begin
                                st_next.phase = PH_START;
                            end else begin
                                st_next.shift_reg = st_reg.saved_value;
                                st_next.bit_counter = '0;
                                st_next.phase = PH_TX;
                            end
                        end
                    end else begin
                        wc_next = wait_bump(wc_next);
                        if (wait_over(wc_next, cfg.ack_wait_limit)) begin
                            st_next.scl_drive = 1'b1;
                            st_next.error_code = ST_NACK;
                            st_next.sda_drive = 1'b1;
                            st_next.phase = PH_STOP;
                            st_next.quarter = 2'd1;
                            wc_next = '0;
                        end else begin
                            st_next.quarter = 2'd2;
                        end
                    end
                end
            end
        end else if ((st_reg.phase == PH_IDLE) && (item.mode <= MODE_RECOVER)) begin
            st_next.operation = item.mode;
            st_next.error_code = ST_OK;
            st_next.stage = STG_ADDR;
            st_next.sda_drive = 1'b0;
            st_next.scl_drive = 1'b0;
            if (item.mode == MODE_RECOVER) begin
                st_next.phase = PH_SETTLE;
                st_next.quarter = 2'd0;
                wc_next = '0;
            end else if ((item.mode == MODE_READ) && (item.read_count == 8'd0)) begin
                st_next.error_code = ST_ZERO_LEN;
                o_done = 1'b1;
            end else begin
                st_next.saved_address = item.device_address;
                st_next.saved_register = item.register_address;
                st_next.saved_value = item.write_value;
                st_next.bytes_left = item.read_count;
                st_next.phase = PH_START;
                st_next.quarter = 2'd1;
                wc_next = '0;
            end
        end

        res.scl_pull_low  = st_next.scl_drive;
        res.sda_pull_low  = st_next.sda_drive;
        res.received_byte = o_byte;
        res.byte_valid    = o_valid;
        res.final_byte    = o_final;
        res.done_res      = o_done;
        res.busy_res      = (st_next.phase != PH_IDLE);
        res.status        = o_done ? st_next.error_code : ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
            wc_reg <= '0;
        end else if (step_en) begin
            st_reg <= st_next;
            wc_reg <= wc_next;
        end
    end

endmodule

// ===== design/i2c_master_register_access.sv =====
// ----------------------------------------------------------------------------
// I2C register master - top level
// Stream wrapper with input register, result register and configuration.
// ----------------------------------------------------------------------------
// Each input word is either a command (probe, register write, multi-byte read
// with repeated start, bus recovery) or one bus tick carrying the sampled SDA
// and SCL levels, and every word gives exactly one result word with the
// open-drain drive levels, any received byte and the status. The block takes
// one word per clock cycle while the result stream is not held back; a word
// waits in the input register, and its whole bus step is worked out in a
// single pass of logic into the result register.
// Write configuration only while no transaction is in progress.
module i2c_master_register_access #(
    parameter int WAIT_COUNTER_BITS = i2cmra_pkg::WAIT_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: device_address, register_address, write_value, read_count,
    //        sda_level, scl_level, zero fill
    input  logic [i2cmra_pkg::IN_DATA_W-1:0]    s_tdata,
    // tuser: mode
    input  logic [2:0]                          s_tuser,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: scl_pull_low, sda_pull_low, received_byte, done_res, busy_res,
    //        status, zero fill
    output logic [i2cmra_pkg::OUT_DATA_W-1:0]   m_tdata,
    // tuser: byte_valid
    output logic [0:0]                          m_tuser,
    // tlast: final_byte
    output logic                                m_tlast,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [7:0]                          cfg_data
);
    import i2cmra_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    cfg_t    cfg_reg;
    result_t step_res;
    logic    advance;

    // A word moves on whenever the result register is free or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.mode             <= s_tuser;
            in_item_reg.device_address   <= s_tdata[6:0];
            in_item_reg.register_address <= s_tdata[14:7];
            in_item_reg.write_value      <= s_tdata[22:15];
            in_item_reg.read_count       <= s_tdata[30:23];
            in_item_reg.sda_level        <= s_tdata[31];
            in_item_reg.scl_level        <= s_tdata[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clock_stretch_limit   <= STRETCH_RESET;
            cfg_reg.ack_wait_limit        <= ACK_WAIT_RESET;
            cfg_reg.recovery_pulse_count  <= PULSES_RESET;
            cfg_reg.recovery_settle_ticks <= SETTLE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_STRETCH:  cfg_reg.clock_stretch_limit   <= cfg_data;
                CFG_ACK_WAIT: cfg_reg.ack_wait_limit        <= cfg_data;
                CFG_PULSES:   cfg_reg.recovery_pulse_count  <= cfg_data[3:0];
                CFG_SETTLE:   cfg_reg.recovery_settle_ticks <= cfg_data;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    i2cmra_core #(
        .WAIT_COUNTER_BITS(WAIT_COUNTER_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.status, out_res_reg.busy_res,
                       out_res_reg.done_res, out_res_reg.received_byte,
                       out_res_reg.sda_pull_low, out_res_reg.scl_pull_low};
    assign m_tuser  = out_res_reg.byte_valid;
    assign m_tlast  = out_res_reg.final_byte;

endmodule

// ===== design/i2cmra_checker.sv =====
// ----------------------------------------------------------------------------
// I2C register master - port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "i2c_master_register_access_defines.svh"

module i2cmra_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [i2cmra_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic [0:0]                          m_tuser,
    input logic                                m_tlast
);
    import i2cmra_pkg::*;

    // A stalled result word keeps its contents.
    `I2CMRA_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // With the result register empty, the input side never stalls.
    `I2CMRA_ASSERT_IMPLY(a_no_stall, aclk, aresetn, !m_tvalid, s_tready)

    // A finished transaction leaves the master idle; otherwise status reads ok.
    `I2CMRA_ASSERT_IMPLY(a_done, aclk, aresetn, m_tvalid, m_tdata[10] ? !m_tdata[11] : (m_tdata[13:12] == ST_OK))

    // The last-byte mark only comes with a received byte, mid-transaction.
    `I2CMRA_ASSERT_IMPLY(a_last, aclk, aresetn, m_tvalid && m_tlast, m_tuser[0] && m_tdata[11])

endmodule

bind i2c_master_register_access i2cmra_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/i2c_master_register_access_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register master - stream testbench
// Emulates a slave on the bus ticks and offers commands and ticks to the
// block. A model of the master predicts every result word, and the words that
// come out are checked field by field. The run passes through several timing
// settings, including the largest, the smallest and zero limits.
// ----------------------------------------------------------------------------
module i2c_master_register_access_tb;
    import i2cmra_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NEVER = 1000000;

    typedef enum logic [4:0] {
        BUS_IDLE, BUS_START, BUS_TX, BUS_ACK, BUS_RX, BUS_MACK, BUS_STOP, BUS_SETTLE, BUS_PULSE
    } bus_phase_e;

    // Which byte of the transfer has been sent: address, register, then data
    // or the repeated-start address.
    typedef enum logic [1:0] {XFER_ADDR, XFER_REG, XFER_DATA} xfer_e;

    typedef struct packed {
        cfg_t       cfg;
        bus_phase_e phase;
        logic [1:0] qs;
        logic [2:0] op;
        logic [3:0] bits;
        logic [7:0] left;
        logic [7:0] sh;
        logic [7:0] wcnt;
        logic [6:0] addr;
        logic [7:0] reg_a;
        logic [7:0] val;
        logic [1:0] err;
        xfer_e      stage;
        logic       scl_pl;
        logic       sda_pl;
        logic       o_valid;
        logic       o_final;
        logic       o_done;
        logic [7:0] o_byte;
    } bus_state_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [2:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [7:0]            cfg_data = '0;

    item_t      pending_items[$];
    result_t    expected_words[$];
    item_t      on_bus;
    bus_state_t gen_state;
    bus_state_t check_state;
    int         items_made = 0;
    int         items_taken = 0;
    int         words_seen = 0;
    int         hold_left = 0;
    int         errors = 0;
    int         cycles = 0;

    i2c_master_register_access dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Master model
    // ------------------------------------------------------------------------
    function automatic bus_state_t bus_reset_state();
        bus_state_t m;
        m = '0;
        m.cfg.clock_stretch_limit = STRETCH_RESET;
        m.cfg.ack_wait_limit = ACK_WAIT_RESET;
        m.cfg.recovery_pulse_count = PULSES_RESET;
        m.cfg.recovery_settle_ticks = SETTLE_RESET;
        m.phase = BUS_IDLE;
        m.stage = XFER_ADDR;
        return m;
    endfunction

    function automatic void apply_cfg(inout bus_state_t m, input logic [1:0] idx,
                                      input logic [7:0] data);
        case (idx)
            CFG_STRETCH: m.cfg.clock_stretch_limit = data;
            CFG_ACK_WAIT: m.cfg.ack_wait_limit = data;
            CFG_PULSES: m.cfg.recovery_pulse_count = data[3:0];
            default: m.cfg.recovery_settle_ticks = data;
        endcase
    endfunction

    function automatic void go(inout bus_state_t m, input bus_phase_e p, input logic [1:0] q);
        m.phase = p;
        m.qs = q;
        m.wcnt = '0;
    endfunction

    // Counts one waiting tick; the counter saturates, which also ends the wait.
    function automatic bit wait_tick(inout bus_state_t m, input logic [7:0] lim);
        if (m.wcnt != 8'hFF) m.wcnt = m.wcnt + 8'd1;
        return (m.wcnt >= lim) || (m.wcnt == 8'hFF);
    endfunction

    function automatic void stop_now(inout bus_state_t m, input logic [1:0] code);
        m.err = code;
        m.sda_pl = 1'b1;
        go(m, BUS_STOP, 2'd1);
    endfunction

    function automatic void send_byte(inout bus_state_t m, input logic [7:0] b);
        m.sh = b;
        m.bits = '0;
        go(m, BUS_TX, 2'd0);
    endfunction

    function automatic void end_transfer(inout bus_state_t m);
        m.o_done = 1'b1;
        go(m, BUS_IDLE, 2'd0);
    endfunction

    function automatic void ack_check(inout bus_state_t m, input logic sda);
        if (!sda) begin
            m.scl_pl = 1'b1;
            if (m.op == MODE_PROBE || m.stage == XFER_DATA) begin
                if (m.op == MODE_READ) begin
                    m.bits = '0;
                    m.sh = '0;
                    m.sda_pl = 1'b0;
                    go(m, BUS_RX, 2'd0);
                end else begin
                    go(m, BUS_STOP, 2'd0);
                end
            end else if (m.stage == XFER_ADDR) begin
                m.stage = XFER_REG;
                send_byte(m, m.reg_a);
            end else begin
                m.stage = XFER_DATA;
                if (m.op == MODE_READ) go(m, BUS_START, 2'd0);
                else send_byte(m, m.val);
            end
        end else if (wait_tick(m, m.cfg.ack_wait_limit)) begin
            m.scl_pl = 1'b1;
            stop_now(m, ST_NACK);
        end else begin
            m.qs = 2'd2;
        end
    endfunction

    // Advances the master by one word and returns the result word it gives.
    function automatic result_t i2c_predict_word(inout bus_state_t m, input item_t it);
        result_t    r;
        logic [1:0] q;
        logic       sda;
        logic       scl;
        m.o_valid = 1'b0;
        m.o_final = 1'b0;
        m.o_done = 1'b0;
        m.o_byte = '0;
        q = m.qs;
        sda = it.sda_level;
        scl = it.scl_level;
        if (it.mode == MODE_TICK) begin
            if (m.phase != BUS_IDLE) begin
                case (m.phase)
                    BUS_START: begin
                        if (q == 2'd0) begin
                            m.sda_pl = 1'b0;
                            m.scl_pl = 1'b0;
                            go(m, BUS_START, 2'd1);
                        end else if (q == 2'd1) begin
                            if (scl) begin
                                m.sda_pl = 1'b1;
                                go(m, BUS_START, 2'd2);
                            end else if (wait_tick(m, m.cfg.clock_stretch_limit)) begin
                                stop_now(m, ST_TIMEOUT);
                            end
                        end else begin
                            m.scl_pl = 1'b1;
                            send_byte(m, {m.addr, m.stage == XFER_DATA});
                        end
                    end
                    BUS_TX: begin
                        if (q == 2'd0) begin
                            m.scl_pl = 1'b1;
                            m.sda_pl = ~m.sh[7];
                            go(m, BUS_TX, 2'd1);
                        end else if (q == 2'd1) begin
                            m.scl_pl = 1'b0;
                            go(m, BUS_TX, 2'd2);
                        end else if (scl) begin
                            m.scl_pl = 1'b1;
                            m.sh = {m.sh[6:0], 1'b0};
                            m.bits = m.bits + 4'd1;
                            go(m, (m.bits >= 4'd8) ? BUS_ACK : BUS_TX, 2'd0);
                        end else if (wait_tick(m, m.cfg.clock_stretch_limit)) begin
                            stop_now(m, ST_TIMEOUT);
                        end
                    end
                    BUS_ACK: begin
                        if (q == 2'd0) begin
                            m.sda_pl = 1'b0;
                            m.scl_pl = 1'b0;
                            go(m, BUS_ACK, 2'd1);
                        end else if (q == 2'd1) begin
                            if (scl) begin
                                m.wcnt = '0;
                                ack_check(m, sda);
                            end else if (wait_tick(m, m.cfg.clock_stretch_limit)) begin
                                stop_now(m, ST_TIMEOUT);
                            end
                        end else begin
                            ack_check(m, sda);
                        end
                    end
                    BUS_RX: begin
                        if (q == 2'd0) begin
                            m.scl_pl = 1'b1;
                            go(m, BUS_RX, 2'd1);
                        end else if (q == 2'd1) begin
                            m.scl_pl = 1'b0;
                            go(m, BUS_RX, 2'd2);
                        end else if (scl) begin
                            m.sh = {m.sh[6:0], sda};
                            m.scl_pl = 1'b1;
                            m.bits = m.bits + 4'd1;
                            if (m.bits >= 4'd8) begin
                                m.o_valid = 1'b1;
                                m.o_byte = m.sh;
                                m.o_final = (m.left <= 8'd1);
                                go(m, BUS_MACK, 2'd0);
                            end else begin
                                go(m, BUS_RX, 2'd0);
                            end
                        end else if (wait_tick(m, m.cfg.clock_stretch_limit)) begin
                            stop_now(m, ST_TIMEOUT);
                        end
                    end
                    BUS_MACK: begin
                        if (q == 2'd0) begin
                            m.scl_pl = 1'b1;
                            m.sda_pl = (m.left > 8'd1);
                            go(m, BUS_MACK, 2'd1);
                        end else if (q == 2'd1) begin
                            m.scl_pl = 1'b0;
                            go(m, BUS_MACK, 2'd2);
                        end else if (scl) begin
                            m.scl_pl = 1'b1;
                            m.sda_pl = 1'b0;
                            if (m.left <= 8'd1) begin
                                m.left = '0;
                                go(m, BUS_STOP, 2'd0);
                            end else begin
                                m.left = m.left - 8'd1;
                                m.bits = '0;
                                m.sh = '0;
                                go(m, BUS_RX, 2'd0);
                            end
                        end else if (wait_tick(m, m.cfg.clock_stretch_limit)) begin
                            stop_now(m, ST_TIMEOUT);
                        end
                    end
                    BUS_STOP: begin
                        if (q == 2'd0) begin
                            m.sda_pl = 1'b1;
                            go(m, BUS_STOP, 2'd1);
                        end else if (q == 2'd1) begin
                            m.scl_pl = 1'b0;
                            go(m, BUS_STOP, 2'd2);
                        end else if (q == 2'd2) begin
                            // A stop whose clock never rises still goes ahead.
                            if (scl) go(m, BUS_STOP, 2'd3);
                            else if (wait_tick(m, m.cfg.clock_stretch_limit))
                                go(m, BUS_STOP, 2'd3);
                        end else begin
                            m.sda_pl = 1'b0;
                            end_transfer(m);
                        end
                    end
                    BUS_SETTLE: begin
                        if (wait_tick(m, m.cfg.recovery_settle_ticks)) begin
                            if (sda) begin
                                end_transfer(m);
                            end else begin
                                m.bits = '0;
                                go(m, BUS_PULSE, 2'd0);
                            end
                        end
                    end
                    BUS_PULSE: begin
                        if (q == 2'd0) begin
                            m.scl_pl = 1'b1;
                            go(m, BUS_PULSE, 2'd1);
                        end else if (q == 2'd1) begin
                            m.scl_pl = 1'b0;
                            go(m, BUS_PULSE, 2'd2);
                        end else begin
                            m.bits = m.bits + 4'd1;
                            if (sda || m.bits >= m.cfg.recovery_pulse_count)
                                stop_now(m, ST_OK);
                            else
                                go(m, BUS_PULSE, 2'd0);
                        end
                    end
                    default: go(m, BUS_IDLE, 2'd0);
                endcase
            end
        end else if (m.phase == BUS_IDLE && it.mode <= MODE_RECOVER) begin
            m.op = it.mode;
            m.err = ST_OK;
            m.stage = XFER_ADDR;
            m.sda_pl = 1'b0;
            m.scl_pl = 1'b0;
            if (it.mode == MODE_RECOVER) begin
                go(m, BUS_SETTLE, 2'd0);
            end else if (it.mode == MODE_READ && it.read_count == 8'd0) begin
                m.err = ST_ZERO_LEN;
                m.o_done = 1'b1;
            end else begin
                m.addr = it.device_address;
                m.reg_a = it.register_address;
                m.val = it.write_value;
                m.left = it.read_count;
                go(m, BUS_START, 2'd1);
            end
        end
        r.scl_pull_low = m.scl_pl;
        r.sda_pull_low = m.sda_pl;
        r.received_byte = m.o_valid ? m.o_byte : 8'd0;
        r.byte_valid = m.o_valid;
        r.final_byte = m.o_valid & m.o_final;
        r.done_res = m.o_done;
        r.busy_res = (m.phase != BUS_IDLE);
        r.status = m.o_done ? m.err : ST_OK;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_words.push_back(i2c_predict_word(check_state, on_bus));
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >=
                    (items_taken < 300 ? 30 : items_taken < 600 ? 59 : 0)) begin
                    on_bus = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, on_bus.scl_level, on_bus.sda_level, on_bus.read_count,
                                on_bus.write_value, on_bus.register_address,
                                on_bus.device_address};
                    s_tuser <= on_bus.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.scl_pull_low = m_tdata[0];
                got.sda_pull_low = m_tdata[1];
                got.received_byte = m_tdata[9:2];
                got.done_res = m_tdata[10];
                got.busy_res = m_tdata[11];
                got.status = m_tdata[13:12];
                got.byte_valid = m_tuser[0];
                got.final_byte = m_tlast;
                words_seen++;
                if (expected_words.size() == 0) begin
                    $error("result word with no expectation waiting");
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("scl_pull_low", want.scl_pull_low, got.scl_pull_low);
                    check_field("sda_pull_low", want.sda_pull_low, got.sda_pull_low);
                    check_field("received_byte", want.received_byte, got.received_byte);
                    check_field("byte_valid", want.byte_valid, got.byte_valid);
                    check_field("final_byte", want.final_byte, got.final_byte);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("status", want.status, got.status);
                end
                // Long back-pressure so that the block fills and stalls its input.
                if (words_seen == 150 || words_seen == 520) hold_left = 200;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >=
                             (items_taken < 300 ? 59 : items_taken < 600 ? 30 : 0));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic item_t random_cmd();
        item_t c;
        int    r;
        c.device_address = $urandom_range(0, 127);
        c.register_address = $urandom_range(0, 255);
        c.write_value = $urandom_range(0, 255);
        c.sda_level = $urandom_range(0, 1);
        c.scl_level = $urandom_range(0, 1);
        r = $urandom_range(0, 99);
        c.mode = r < 20 ? MODE_PROBE : r < 50 ? MODE_WRITE : r < 85 ? MODE_READ : MODE_RECOVER;
        r = $urandom_range(0, 99);
        c.read_count = r < 10 ? 8'd0 : r < 80 ? 8'($urandom_range(1, 3)) :
                       8'($urandom_range(4, 255));
        return c;
    endfunction

    // Steps the generator's own model so that the slave can answer the master.
    task automatic offer(input item_t t);
        void'(i2c_predict_word(gen_state, t));
        pending_items.push_back(t);
        items_made++;
    endtask

    // Offers a command and then bus ticks until the transfer has ended.
    // stuck: 0 random SDA in recovery, 1 held low, 2 released.
    task automatic run_transfer(input item_t cmd, input bit refuse, input int stuck,
                                input int stretch_from, input int noise_at);
        item_t t;
        int    n;
        logic  sda;
        logic  scl;
        n = 0;
        offer(cmd);
        while (gen_state.phase != BUS_IDLE) begin
            if (n == noise_at || $urandom_range(0, 99) < 3) begin
                t = random_cmd();
                if ($urandom_range(0, 3) == 0) t.mode = 3'($urandom_range(5, 7));
                offer(t);
            end
            t = random_cmd();
            t.mode = MODE_TICK;
            if ((n >= stretch_from && n < stretch_from + 300) || n > 600)
                scl = 1'b0;
            else
                scl = ~gen_state.scl_pl & ($urandom_range(0, 19) != 0);
            case (gen_state.phase)
                BUS_ACK: sda = refuse ? 1'b1 : ($urandom_range(0, 4) == 0);
                BUS_RX: sda = $urandom_range(0, 1);
                BUS_SETTLE: sda = stuck == 1 ? 1'b0 : stuck == 2 ? 1'b1 : $urandom_range(0, 1);
                BUS_PULSE: sda = stuck == 1 ? 1'b0 : stuck == 2 ? 1'b1 :
                                 ($urandom_range(0, 7) == 0);
                default: sda = ~gen_state.sda_pl ^ ($urandom_range(0, 49) == 0);
            endcase
            t.sda_level = sda;
            t.scl_level = scl;
            offer(t);
            n++;
        end
    endtask

    task automatic run_traffic(input int count);
        item_t t;
        int    stop_at;
        int    r;
        stop_at = items_made + count;
        while (items_made < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                t = random_cmd();
                t.mode = MODE_TICK;
                offer(t);
            end else if (r < 9) begin
                t = random_cmd();
                t.mode = 3'($urandom_range(5, 7));
                offer(t);
            end else begin
                run_transfer(random_cmd(), $urandom_range(0, 9) == 0, 0,
                             $urandom_range(0, 3) == 0 ? $urandom_range(0, 120) : NEVER, -1);
            end
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        apply_cfg(gen_state, idx, data);
        apply_cfg(check_state, idx, data);
    endtask

    initial begin
        item_t      c;
        logic [7:0] lim_stretch[5];
        logic [7:0] lim_ack[5];
        logic [3:0] lim_pulses[5];
        logic [7:0] lim_settle[5];
        gen_state = bus_reset_state();
        check_state = bus_reset_state();
        lim_stretch = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(2, 30)), STRETCH_RESET};
        lim_ack = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(2, 30)), ACK_WAIT_RESET};
        lim_pulses = '{4'd15, 4'd1, 4'd0, 4'($urandom_range(2, 14)), PULSES_RESET};
        lim_settle = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(2, 30)), SETTLE_RESET};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words at the reset settings.
        c = '{MODE_TICK, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1};
        offer(c);
        c = '{MODE_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0};
        offer(c);
        for (int m = 5; m <= 7; m++) begin
            c = '{3'(m), 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1};
            offer(c);
        end
        c = '{MODE_READ, 7'h7F, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1};
        offer(c);
        c = '{MODE_PROBE, 7'h7F, 8'h00, 8'h00, 8'h01, 1'b0, 1'b0};
        run_transfer(c, 1'b0, 0, NEVER, 2);
        c = '{MODE_WRITE, 7'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0};
        run_transfer(c, 1'b0, 0, NEVER, 4);
        c = '{MODE_READ, 7'h2A, 8'h00, 8'h5A, 8'h02, 1'b0, 1'b1};
        run_transfer(c, 1'b0, 0, NEVER, 2);
        c = '{MODE_READ, 7'h55, 8'h80, 8'hA5, 8'h01, 1'b1, 1'b1};
        run_transfer(c, 1'b0, 0, NEVER, -1);
        c = '{MODE_PROBE, 7'h11, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0};
        run_transfer(c, 1'b1, 0, NEVER, -1);
        c = '{MODE_WRITE, 7'h33, 8'h12, 8'h34, 8'h00, 1'b0, 1'b0};
        run_transfer(c, 1'b0, 0, 20, -1);
        c = '{MODE_READ, 7'h40, 8'h22, 8'h00, 8'hFF, 1'b0, 1'b0};
        run_transfer(c, 1'b0, 0, 60, -1);
        c = '{MODE_RECOVER, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0};
        run_transfer(c, 1'b0, 2, NEVER, 3);
        run_transfer(c, 1'b0, 1, NEVER, -1);
        run_transfer(c, 1'b0, 0, NEVER, -1);
        drain();

        // Random traffic under each timing setting.
        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_STRETCH, lim_stretch[p]);
            write_reg(CFG_ACK_WAIT, lim_ack[p]);
            write_reg(CFG_PULSES, {4'($urandom_range(0, 15)), lim_pulses[p]});
            write_reg(CFG_SETTLE, lim_settle[p]);
            @(negedge aclk);
            run_traffic(170);
            drain();
        end

        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/i2cmra_pkg.sv
design/i2cmra_core.sv
design/i2c_master_register_access.sv
design/i2cmra_checker.sv
sim/i2c_master_register_access_tb.sv
